[src/ctcgd_pkg.sv]
// ----------------------------------------------------------------------------
// ctcgd_pkg
// Shared widths, types and controller/datapath signal groups for the CTC
// greedy decoder.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

    localparam int SCORE_W     = 16;
    localparam int CLASS_W     = 15;
    localparam int MAX_CLASSES = 32768;
    localparam int POS_W       = $clog2(MAX_CLASSES + 1);
    localparam int DICT_W      = 15;
    localparam int MAX_STEPS   = 1024;
    localparam int COUNT_W     = $clog2(MAX_STEPS + 1);
    localparam int SUM_W       = SCORE_W + COUNT_W - 1;
    localparam int DIV_STEPS   = SUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic KIND_TOKEN   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef logic signed [SCORE_W-1:0] t_score;
    typedef logic signed [SUM_W-1:0]   t_sum;

    typedef enum logic [1:0] {
        S_RUN,
        S_LOAD,
        S_DIV,
        S_SUM
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic div_load;
        logic div_step;
        logic sum_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic in_close_seq;
        logic out_free;
        logic div_last;
    } t_stat;

endpackage

[src/ctcgd_in_if.sv]
// ----------------------------------------------------------------------------
// ctcgd_in_if
// Score channel: one class score per word with step and sequence flags.
// ----------------------------------------------------------------------------
interface ctcgd_in_if;
    logic               valid;
    logic               ready;
    ctcgd_pkg::t_score  score;
    logic               last_class;
    logic               last_step;

    modport source (output valid, output score, output last_class, output last_step,
                    input ready);
    modport sink   (input valid, input score, input last_class, input last_step,
                    output ready);
endinterface

[src/ctcgd_out_if.sv]
// ----------------------------------------------------------------------------
// ctcgd_out_if
// Result channel: token words and end-of-sequence summary words.
// ----------------------------------------------------------------------------
interface ctcgd_out_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [ctcgd_pkg::DICT_W-1:0]      token_index;
    logic                              is_space;
    ctcgd_pkg::t_score                 confidence;
    logic [ctcgd_pkg::COUNT_W-1:0]     token_count;
    logic                              last;

    modport source (output valid, output kind, output token_index, output is_space,
                    output confidence, output token_count, output last, input ready);
    modport sink   (input valid, input kind, input token_index, input is_space,
                    input confidence, input token_count, input last, output ready);
endinterface

[src/ctcgd_ctrl.sv]
// ----------------------------------------------------------------------------
// ctcgd_ctrl
// Sequencer: streams scores, then runs the averaging divide and emits the
// summary word at sequence end.
// ----------------------------------------------------------------------------
module ctcgd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ctcgd_pkg::t_stat i_stat,
    output ctcgd_pkg::t_cmd  o_cmd
);
    import ctcgd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_RUN: begin
                o_cmd.in_ready = i_stat.out_free;
                o_cmd.accept   = i_stat.out_free && i_stat.in_valid;
                if (o_cmd.accept && i_stat.in_close_seq) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                // hold until the output register can take the summary word
                if (i_stat.out_free) begin
                    o_cmd.sum_load = 1'b1;
                    n_state        = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end
endmodule

[src/ctcgd_datapath.sv]
// ----------------------------------------------------------------------------
// ctcgd_datapath
// Per-step argmax, collapse of blanks and repeats, running sum and count,
// bit-serial averaging divide and the output word register.
// ----------------------------------------------------------------------------
module ctcgd_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ctcgd_pkg::t_cmd                i_cmd,
    output ctcgd_pkg::t_stat               o_stat,
    input  logic                           i_cfg_we,
    input  logic [ctcgd_pkg::DICT_W-1:0]   i_cfg_wdata,
    input  logic                           i_in_valid,
    input  ctcgd_pkg::t_score              i_score,
    input  logic                           i_last_class,
    input  logic                           i_last_step,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_kind,
    output logic [ctcgd_pkg::DICT_W-1:0]   o_token_index,
    output logic                           o_is_space,
    output ctcgd_pkg::t_score              o_confidence,
    output logic [ctcgd_pkg::COUNT_W-1:0]  o_token_count,
    output logic                           o_last
);
    import ctcgd_pkg::*;

    logic [DICT_W-1:0]    r_dict_size;
    t_score               r_best_score;
    logic [CLASS_W-1:0]   r_best_class;
    logic [POS_W-1:0]     r_class_pos;
    logic [CLASS_W-1:0]   r_prev_winner;
    logic                 r_prev_valid;
    t_sum                 r_score_sum;
    logic [COUNT_W-1:0]   r_count;

    logic [COUNT_W-1:0]   r_rem;
    logic [SUM_W-1:0]     r_quo;
    logic [COUNT_W-1:0]   r_divisor;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 r_div_neg;
    logic                 r_div_zero;

    logic                 r_out_valid;

    // scan and close-step logic
    logic                 w_pos_ok;
    logic                 w_take;
    t_score               w_best_score;
    logic [CLASS_W-1:0]   w_best_class;
    logic                 w_counted;
    logic [DICT_W-1:0]    w_key;
    logic                 w_emit;
    logic                 w_space;
    logic                 w_add;

    // divide step
    logic [COUNT_W:0]     w_trial;
    logic                 w_fit;
    logic [SCORE_W-1:0]   w_quo_lo;
    t_score               w_conf;

    assign w_pos_ok     = r_class_pos < POS_W'(MAX_CLASSES);
    assign w_take       = w_pos_ok && ((r_class_pos == '0) || (i_score > r_best_score));
    assign w_best_score = w_take ? i_score : r_best_score;
    assign w_best_class = w_take ? r_class_pos[CLASS_W-1:0] : r_best_class;
    assign w_counted    = (w_best_class != '0)
                       && (!r_prev_valid || (w_best_class != r_prev_winner));
    assign w_key        = DICT_W'(w_best_class - CLASS_W'(1));
    assign w_emit       = w_counted && (w_key <= r_dict_size);
    assign w_space      = w_key == r_dict_size;
    assign w_add        = w_counted && (r_count < COUNT_W'(MAX_STEPS));

    assign w_trial  = {r_rem, r_quo[SUM_W-1]};
    assign w_fit    = w_trial >= {1'b0, r_divisor};
    assign w_quo_lo = r_quo[SCORE_W-1:0];
    assign w_conf   = r_div_zero ? '0 : (r_div_neg ? t_score'(-w_quo_lo) : t_score'(w_quo_lo));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dict_size <= DICT_W'(1);
        end else if (i_cfg_we) begin
            r_dict_size <= i_cfg_wdata;
        end
    end

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_score  <= '0;
            r_best_class  <= '0;
            r_class_pos   <= '0;
            r_prev_winner <= '0;
            r_prev_valid  <= 1'b0;
            r_score_sum   <= '0;
            r_count       <= '0;
        end else if (i_cmd.sum_load) begin
            r_prev_valid <= 1'b0;
            r_score_sum  <= '0;
            r_count      <= '0;
        end else if (i_cmd.accept) begin
            if (i_last_class) begin
                r_best_score  <= '0;
                r_best_class  <= '0;
                r_class_pos   <= '0;
                r_prev_winner <= w_best_class;
                r_prev_valid  <= 1'b1;
                if (w_add) begin
                    r_score_sum <= r_score_sum + t_sum'(w_best_score);
                    r_count     <= r_count + COUNT_W'(1);
                end
            end else begin
                r_best_score <= w_best_score;
                r_best_class <= w_best_class;
                if (w_pos_ok) begin
                    r_class_pos <= r_class_pos + POS_W'(1);
                end
            end
        end
    end

    // restoring divide on the magnitude, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem      <= '0;
            r_quo      <= r_score_sum[SUM_W-1] ? SUM_W'(-r_score_sum) : SUM_W'(r_score_sum);
            r_divisor  <= r_count;
            r_div_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            r_div_neg  <= r_score_sum[SUM_W-1];
            r_div_zero <= r_count == '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= w_fit ? COUNT_W'(w_trial - {1'b0, r_divisor}) : COUNT_W'(w_trial);
            r_quo     <= {r_quo[SUM_W-2:0], w_fit};
            r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.sum_load || (i_cmd.accept && i_last_class && w_emit)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_load) begin
            o_kind        <= KIND_SUMMARY;
            o_token_index <= '0;
            o_is_space    <= 1'b0;
            o_confidence  <= w_conf;
            o_token_count <= r_count;
            o_last        <= 1'b1;
        end else if (i_cmd.accept && i_last_class && w_emit) begin
            o_kind        <= KIND_TOKEN;
            o_token_index <= w_key;
            o_is_space    <= w_space;
            o_confidence  <= '0;
            o_token_count <= '0;
            o_last        <= 1'b0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_stat.in_valid     = i_in_valid;
    assign o_stat.in_close_seq = i_last_class && i_last_step;
    assign o_stat.out_free     = !r_out_valid || i_out_ready;
    assign o_stat.div_last     = r_div_cnt == '0;
endmodule

[src/ctc_greedy_decoder_core.sv]
// ----------------------------------------------------------------------------
// ctc_greedy_decoder_core
// CTC greedy decoder: per-step argmax over streamed class scores, collapse
// of blanks and repeats, token words and an average-confidence summary.
// ----------------------------------------------------------------------------
// Usage
//   i_in carries one class score word per handshake, class 0 first; last_class
//   closes a time step, last_step on that same word closes the sequence.
//   o_out returns token words (kind 0) and one summary word (kind 1, last 1)
//   per sequence. i_cfg_we/i_cfg_wdata set the dictionary size; write it only
//   while the block is idle.
//   Throughput: one score word per cycle while the output register drains.
//   A token word shows on o_out the cycle after its closing score word.
//   Sequence end: a load state, then the bit-serial divider steps (one
//   quotient bit per cycle over the 26-bit sum), then the summary word is
//   loaded; i_in is held off until then.
//   Reset: dictionary size 1, sequence state cleared, no word pending.
//   Receiver stall: the output register holds its word and i_in.ready drops
//   until the word is taken, so no result is lost or overwritten.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ctcgd_pkg::DICT_W-1:0]  i_cfg_wdata,
    ctcgd_in_if.sink                      i_in,
    ctcgd_out_if.source                   o_out
);
    import ctcgd_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: decides when a score word is taken and drives the divider
    ctcgd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // argmax, collapse, sum/count, divider and output word
    ctcgd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in.valid),
        .i_score       (i_in.score),
        .i_last_class  (i_in.last_class),
        .i_last_step   (i_in.last_step),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_kind        (o_out.kind),
        .o_token_index (o_out.token_index),
        .o_is_space    (o_out.is_space),
        .o_confidence  (o_out.confidence),
        .o_token_count (o_out.token_count),
        .o_last        (o_out.last)
    );

    // input is taken only when the output register has room for a token
    assign i_in.ready = w_cmd.in_ready;

`ifndef SYNTH
    // a closing word of a sequence starts the divider on the next cycle
    a_seq_end_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.last_class && i_in.last_step |=> w_cmd.div_load)
        else $error("sequence end did not start the divider");

    // the summary never overwrites a word still waiting on o_out
    a_sum_into_free_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.sum_load |-> (!o_out.valid || o_out.ready))
        else $error("summary loaded over a pending word");

    // no score word is taken while the divider runs
    a_no_accept_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.div_load || w_cmd.div_step) |-> !i_in.ready)
        else $error("input accepted during divide");
`endif
endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives class score words into the CTC greedy decoder core and checks every
// token and summary word against a cycle-free prediction of the decode. Covers
// hand-picked corner sequences and random sequences under several dictionary
// sizes, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------

import ctcgd_pkg::*;

// One result word as the block presents it.
typedef struct packed {
    logic               kind;
    logic [DICT_W-1:0]  token_index;
    logic               is_space;
    t_score             confidence;
    logic [COUNT_W-1:0] token_count;
    logic               last;
} decode_word_t;

// One class score word as the sender presents it.
typedef struct packed {
    t_score score;
    logic   last_class;
    logic   last_step;
} score_word_t;

class ctc_decode_scoreboard;
    logic [DICT_W-1:0]  dictionary_size;
    t_score             step_best;
    logic [CLASS_W-1:0] step_winner;
    int                 class_pos;
    int                 prior_winner;
    longint             score_total;
    int                 counted;
    decode_word_t       expected_words[$];
    int                 errors;

    function new();
        dictionary_size = 1;
        errors = 0;
        clear_sequence();
    endfunction

    function void clear_sequence();
        step_best    = '0;
        step_winner  = '0;
        class_pos    = 0;
        prior_winner = -1;
        score_total  = 0;
        counted      = 0;
    endfunction

    // Fold one accepted score word into the decode and queue the words it causes.
    function void note_score(t_score s, logic close_step, logic close_seq);
        int           w;
        int           key;
        decode_word_t r;
        if (class_pos < MAX_CLASSES) begin
            if (class_pos == 0 || s > step_best) begin
                step_best   = s;
                step_winner = class_pos[CLASS_W-1:0];
            end
            class_pos++;
        end
        if (!close_step)
            return;
        w = step_winner;
        if (w != 0 && w != prior_winner) begin
            key = w - 1;
            if (key <= dictionary_size) begin
                r             = '0;
                r.kind        = KIND_TOKEN;
                r.token_index = key[DICT_W-1:0];
                r.is_space    = (key == dictionary_size);
                expected_words = {expected_words, r};
            end
            if (counted < MAX_STEPS) begin
                score_total += step_best;
                counted++;
            end
        end
        prior_winner = w;
        step_best    = '0;
        step_winner  = '0;
        class_pos    = 0;
        if (close_seq) begin
            r             = '0;
            r.kind        = KIND_SUMMARY;
            r.confidence  = (counted > 0) ? t_score'(score_total / longint'(counted)) : '0;
            r.token_count = counted[COUNT_W-1:0];
            r.last        = 1'b1;
            expected_words = {expected_words, r};
            clear_sequence();
        end
    endfunction

    function void compare(string field, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            errors++;
        end
    endfunction

    // Match one accepted result word against the oldest expectation.
    function void check_word(decode_word_t got);
        decode_word_t want;
        if (expected_words.size() == 0) begin
            $error("result word with none expected: kind %0d index %0d count %0d",
                   got.kind, got.token_index, got.token_count);
            errors++;
            return;
        end
        want = expected_words.pop_front();
        compare("kind", want.kind, got.kind);
        compare("token_index", want.token_index, got.token_index);
        compare("is_space", want.is_space, got.is_space);
        compare("confidence", $signed(want.confidence), $signed(got.confidence));
        compare("token_count", want.token_count, got.token_count);
        compare("last", want.last, got.last);
    endfunction
endclass

module testbench;

    localparam int DICT_MAX     = 32767;
    localparam int DRAIN_CYCLES = 40;    // covers the load, divide steps and summary, with margin
    localparam int STALL_LIMIT  = 2000;  // cycles without any accepted word

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [DICT_W-1:0] i_cfg_wdata;

    ctcgd_in_if  in_if ();
    ctcgd_out_if out_if ();

    ctc_greedy_decoder_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if.sink),
        .o_out       (out_if.source)
    );

    always #5 i_clk = ~i_clk;

    ctc_decode_scoreboard decode_sb;

    score_word_t score_feed[$];
    int          words_queued = 0;
    int          words_taken  = 0;
    bit          score_taken  = 1'b0;
    int          quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Sender: pop words from the feed in bursts, hold valid through
    // backpressure, drop valid during gaps or when the feed runs dry.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        score_word_t w;
        if (i_rst_n && (!in_if.valid || score_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (score_feed.size() != 0) begin
                w = score_feed.pop_front();
                in_if.valid      <= 1'b1;
                in_if.score      <= w.score;
                in_if.last_class <= w.last_class;
                in_if.last_step  <= w.last_step;
                burst_left--;
                if (burst_left <= 0) begin
                    // mostly short bursts, now and then a long unbroken run
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                             : $urandom_range(1, 30);
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: alternate open and closed windows; some open windows are
    // long so that stretches run with no stall at all.
    // ------------------------------------------------------------------
    bit sink_open = 1'b0;
    int sink_left = 0;

    always @(negedge i_clk) begin
        if (sink_left == 0) begin
            sink_open = !sink_open;
            if (sink_open)
                sink_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 20);
            else
                sink_left = $urandom_range(1, 12);
        end
        sink_left--;
        out_if.ready <= sink_open;
    end

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge, feed the
    // predictor, check results, and run the no-progress watchdog.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        decode_word_t got;
        bit           result_taken;
        score_taken  = i_rst_n && in_if.valid && in_if.ready;
        result_taken = i_rst_n && out_if.valid && out_if.ready;
        if (score_taken) begin
            decode_sb.note_score(in_if.score, in_if.last_class, in_if.last_step);
            words_taken++;
        end
        if (result_taken) begin
            got.kind        = out_if.kind;
            got.token_index = out_if.token_index;
            got.is_space    = out_if.is_space;
            got.confidence  = out_if.confidence;
            got.token_count = out_if.token_count;
            got.last        = out_if.last;
            decode_sb.check_word(got);
        end
        if (score_taken || result_taken)
            quiet_cycles = 0;
        else if (i_rst_n)
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_word(t_score s, logic close_step, logic close_seq);
        score_word_t w;
        w.score      = s;
        w.last_class = close_step;
        w.last_step  = close_seq;
        score_feed = {score_feed, w};
        words_queued++;
    endfunction

    // One time step of random content. Styles: full-range scores, a narrow
    // band that breeds ties, or one clear winner above the rest.
    function automatic void queue_step(int classes, int style, bit close_seq);
        int     top;
        t_score v;
        top = $urandom_range(0, classes - 1);
        for (int c = 0; c < classes; c++) begin
            case (style)
                0:       v = t_score'($urandom);
                1:       v = t_score'($urandom_range(0, 4) - 2);
                default: v = (c == top) ? t_score'($urandom_range(16384, 32767))
                                        : t_score'($urandom_range(0, 49151) - 32768);
            endcase
            if (c == classes - 1)
                queue_word(v, 1'b1, close_seq);
            else
                queue_word(v, 1'b0, $urandom_range(0, 9) == 0);  // stray step flag
        end
    endfunction

    // Corner sequences, with the dictionary size at its reset value of one:
    // key 0 is a token, key 1 the space, anything above is counted but silent.
    function automatic void queue_corners();
        // blank-only sequence: summary with zero count and zero confidence
        queue_word(-16'sd32768, 1'b1, 1'b1);
        // stray step flag ignored; lowest winning score
        queue_word(-16'sd32768, 1'b0, 1'b1);
        queue_word(-16'sd32767, 1'b1, 1'b0);
        // same winner again: collapsed
        queue_word(16'sd0, 1'b0, 1'b0);
        queue_word(16'sd5, 1'b1, 1'b0);
        // three-way tie: first class keeps it, blank
        queue_word(16'sd7, 1'b0, 1'b0);
        queue_word(16'sd7, 1'b0, 1'b0);
        queue_word(16'sd7, 1'b1, 1'b0);
        // tie after the blank: class 1 wins and counts again
        queue_word(16'sd0, 1'b0, 1'b0);
        queue_word(16'sd9, 1'b0, 1'b0);
        queue_word(16'sd9, 1'b1, 1'b0);
        // space token
        queue_word(16'sd0, 1'b0, 1'b0);
        queue_word(16'sd1, 1'b0, 1'b0);
        queue_word(16'sd32767, 1'b1, 1'b0);
        // beyond the space class, closing the sequence: summary only
        queue_word(16'sd0, 1'b0, 1'b0);
        queue_word(16'sd0, 1'b0, 1'b0);
        queue_word(16'sd0, 1'b0, 1'b0);
        queue_word(16'sd32767, 1'b1, 1'b1);
        // token and summary from one word, top score
        queue_word(-16'sd1, 1'b0, 1'b0);
        queue_word(16'sd32767, 1'b1, 1'b1);
        // negative average truncates toward zero: (-3 + -4) / 2 = -3
        queue_word(-16'sd5, 1'b0, 1'b0);
        queue_word(-16'sd3, 1'b1, 1'b0);
        queue_word(-16'sd9, 1'b0, 1'b0);
        queue_word(-16'sd8, 1'b0, 1'b0);
        queue_word(-16'sd4, 1'b1, 1'b1);
    endfunction

    // Well-formed random sequences until the budget of words is queued.
    function automatic void queue_random(int budget);
        int start;
        int steps;
        int maxc;
        int classes;
        start = words_queued;
        maxc  = (decode_sb.dictionary_size + 3 < 8) ? decode_sb.dictionary_size + 3 : 8;
        while (words_queued - start < budget) begin
            steps = $urandom_range(1, 8);
            for (int s = 0; s < steps; s++) begin
                classes = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                      : $urandom_range(1, maxc);
                queue_step(classes, $urandom_range(0, 2), s == steps - 1);
            end
        end
    endfunction

    // Hold until every queued word is taken and every result has come back,
    // then let the divider settle before anything else happens.
    task automatic drain();
        while (words_taken != words_queued || decode_sb.expected_words.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_dictionary(input int size);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size[DICT_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        decode_sb.dictionary_size = size[DICT_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    int dict_plan[6] = '{2, 6, DICT_MAX, 3, 0, 1};

    initial begin
        int size;
        decode_sb        = new();
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        in_if.valid      = 1'b0;
        in_if.score      = '0;
        in_if.last_class = 1'b0;
        in_if.last_step  = 1'b0;
        out_if.ready     = 1'b0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corners run on the reset dictionary size
        @(posedge i_clk);
        queue_corners();
        drain();

        // random sequences; a zero in the plan draws a random size
        for (int p = 0; p < 6; p++) begin
            size = (dict_plan[p] == 0) ? $urandom_range(1, DICT_MAX) : dict_plan[p];
            set_dictionary(size);
            @(posedge i_clk);
            queue_random(245);
            drain();
        end

        if (decode_sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/ctcgd_pkg.sv
src/ctcgd_in_if.sv
src/ctcgd_out_if.sv
src/ctcgd_ctrl.sv
src/ctcgd_datapath.sv
src/ctc_greedy_decoder_core.sv
sim/testbench.sv
